FILE: rtl/wfba_pkg.sv
// Shared types and constants for the worst-fit block allocator.
package wfba_pkg;

  // Fixed field widths of the ports
  localparam int OP_W   = 1;
  localparam int SEL_W  = 3;
  localparam int SZ_W   = 16;
  localparam int CFG_W  = 4;

  // Defaults for the top-level parameters
  localparam int NUM_BLOCKS_DEF = 8;
  localparam int SIZE_BITS_DEF  = 16;

  // Reset value of the blocks-in-use register
  localparam logic [CFG_W-1:0] BLOCKS_IN_USE_RST = 4'd8;

  // Item operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } opcode_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_t;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    logic             allocated;
    logic [SEL_W-1:0] block_number;
    logic [SZ_W-1:0]  space_left;
  } res_t;

endpackage

FILE: rtl/wfba_table.sv
// Free-size table: one write port, one registered read port, valid bits per entry.
module wfba_table #(
  parameter int NUM_BLOCKS = 8,
  parameter int SIZE_BITS  = 16,
  parameter int IDX_W      = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [SIZE_BITS-1:0] wr_data,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [SIZE_BITS-1:0] rd_data
);
  import wfba_pkg::*;

  logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] vld;
  logic [SIZE_BITS-1:0] rd_q;
  logic                 rd_vld;

  // Write the storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Mark entries as written; reset clears them all at once
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Register the read port
  always_ff @(posedge clk) begin
    rd_q   <= mem[rd_addr];
    rd_vld <= vld[rd_addr];
  end

  // An entry never written reads as zero
  assign rd_data = rd_vld ? rd_q : '0;

endmodule

FILE: rtl/wfba_seq.sv
// Sequencer and shared comparator that write loads, scan the table and write back the pick.
module wfba_seq #(
  parameter int NUM_BLOCKS = 8,
  parameter int SIZE_BITS  = 16,
  parameter int IDX_W      = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wfba_pkg::OP_W-1:0]     opcode,
  input  logic [wfba_pkg::SEL_W-1:0]    block_select,
  input  logic [wfba_pkg::SZ_W-1:0]     size_value,
  input  logic [wfba_pkg::CFG_W-1:0]    blocks_in_use,
  output logic                          wr_en,
  output logic [IDX_W-1:0]              wr_addr,
  output logic [SIZE_BITS-1:0]          wr_data,
  output logic [IDX_W-1:0]              rd_addr,
  input  logic [SIZE_BITS-1:0]          rd_data,
  output logic                          res_valid,
  input  logic                          res_take,
  output wfba_pkg::res_t                res
);
  import wfba_pkg::*;

  localparam int LIM_W  = ($clog2(NUM_BLOCKS + 1) > CFG_W) ? $clog2(NUM_BLOCKS + 1) : CFG_W;
  localparam int SELX_W = (IDX_W > SEL_W) ? IDX_W : SEL_W;
  localparam int SZX_W  = (SIZE_BITS > SZ_W) ? SIZE_BITS : SZ_W;

  state_t state, state_next;

  logic [LIM_W-1:0]     iss_cnt;
  logic [LIM_W-1:0]     lim;
  logic                 pend;
  logic [IDX_W-1:0]     cmp_idx;
  logic                 found;
  logic [IDX_W-1:0]     pick;
  logic [SIZE_BITS-1:0] best;
  logic [SIZE_BITS:0]   thr;
  logic [SIZE_BITS-1:0] req;
  logic [SIZE_BITS-1:0] left;

  logic                 accept;
  logic                 is_load;
  logic                 load_ok;
  logic                 issue;
  logic                 hit;
  logic [SELX_W-1:0]    sel_ext;
  logic [IDX_W-1:0]     load_idx;
  logic [SZX_W-1:0]     size_ext;
  logic [SIZE_BITS-1:0] size_in;
  logic [LIM_W-1:0]     lim_in;
  logic [SELX_W-1:0]    pick_ext;
  logic [SZX_W-1:0]     left_ext;

  // Fit the input fields to the table widths
  assign sel_ext  = SELX_W'(block_select);
  assign load_idx = sel_ext[IDX_W-1:0];
  assign size_ext = SZX_W'(size_value);
  assign size_in  = size_ext[SIZE_BITS-1:0];
  assign load_ok  = (32'(block_select) < NUM_BLOCKS);
  assign is_load  = (opcode == OP_LOAD);
  assign accept   = in_valid && !in_stall;

  // Saturate the scan length to the table depth
  assign lim_in = (LIM_W'(blocks_in_use) > LIM_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS)
                                                               : LIM_W'(blocks_in_use);

  // Shared comparator: reach the running threshold (request size, then best + 1)
  assign hit = ({1'b0, rd_data} >= thr);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && !is_load) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!issue && !pend) begin
          state_next = found ? S_WRITE : S_DONE;
        end
      end
      S_WRITE: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall  = 1'b1;
    issue     = 1'b0;
    res_valid = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = load_idx;
    wr_data   = size_in;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        wr_en    = in_valid && is_load && load_ok;
      end
      S_SCAN: begin
        issue = (iss_cnt < lim);
      end
      S_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = pick;
        wr_data = best - req;
      end
      S_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign rd_addr = iss_cnt[IDX_W-1:0];

  // State and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      iss_cnt <= '0;
      pend    <= 1'b0;
      found   <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= issue;
      if (state == S_IDLE && accept && !is_load) begin
        iss_cnt <= '0;
        found   <= 1'b0;
      end else begin
        if (issue) begin
          iss_cnt <= iss_cnt + LIM_W'(1);
        end
        if (pend && hit) begin
          found <= 1'b1;
        end
      end
    end
  end

  // Scan datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && !is_load) begin
      req <= size_in;
      lim <= lim_in;
      thr <= {1'b0, size_in};
    end
    cmp_idx <= rd_addr;
    if (state == S_SCAN && pend && hit) begin
      pick <= cmp_idx;
      best <= rd_data;
      thr  <= {1'b0, rd_data} + (SIZE_BITS + 1)'(1);
    end
    if (state == S_WRITE) begin
      left <= best - req;
    end
  end

  // Build the result fields
  assign pick_ext         = SELX_W'(pick);
  assign left_ext         = SZX_W'(left);
  assign res.allocated    = found;
  assign res.block_number = found ? pick_ext[SEL_W-1:0] : '0;
  assign res.space_left   = found ? left_ext[SZ_W-1:0] : '0;

  // Write-back only happens for a found block
  a_write_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> found)
    else $error("write-back without a chosen block");

  // The issue counter never runs past the scan length
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (iss_cnt <= lim))
    else $error("scan counter beyond limit");

  // No read stays pending outside the scan
  a_pend_scan: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == S_SCAN))
    else $error("pending read outside scan");

  // A chosen block always covers the request
  a_best_fits: assert property (@(posedge clk) disable iff (rst)
    (found && state != S_IDLE) |-> (best >= req))
    else $error("chosen block smaller than request");

endmodule

FILE: rtl/worst_fit_block_allocator.sv
// Top level of the worst-fit block allocator: config register, output register, hookup.
//
//   channel   signals                                   direction
//   in        in_valid, in_stall, opcode,               item in
//             block_select, size_value
//   out       out_valid, out_stall, allocated,          item out
//             block_number, space_left
//   cfg       cfg_we, cfg_wdata (blocks_in_use)         write only
//
// A load is written to the table as it is taken. A request scans the first L entries,
// L = min(blocks_in_use, NUM_BLOCKS); its result goes out before the next item is taken:
// one comparator walks the table through its single registered read port, then, when a
// block is granted, the reduced size is written back.
// Reset (rst, synchronous) clears the table through per-entry valid bits at once.
// A result waits in the output register while out_stall is high; a second request
// holds in its last state until that register frees up.
module worst_fit_block_allocator #(
  parameter int NUM_BLOCKS = wfba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = wfba_pkg::SIZE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wfba_pkg::OP_W-1:0]     opcode,
  input  logic [wfba_pkg::SEL_W-1:0]    block_select,
  input  logic [wfba_pkg::SZ_W-1:0]     size_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          allocated,
  output logic [wfba_pkg::SEL_W-1:0]    block_number,
  output logic [wfba_pkg::SZ_W-1:0]     space_left,
  input  logic                          cfg_we,
  input  logic [wfba_pkg::CFG_W-1:0]    cfg_wdata
);
  import wfba_pkg::*;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  logic [CFG_W-1:0]     blocks_in_use;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] wr_data;
  logic [IDX_W-1:0]     rd_addr;
  logic [SIZE_BITS-1:0] rd_data;
  logic                 res_valid;
  logic                 res_take;
  res_t                 res;
  res_t                 out_q;

  // Hold the blocks-in-use register
  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= BLOCKS_IN_USE_RST;
    end else if (cfg_we) begin
      blocks_in_use <= cfg_wdata;
    end
  end

  wfba_table #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS),
    .IDX_W      (IDX_W)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wfba_seq #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS),
    .IDX_W      (IDX_W)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .block_select  (block_select),
    .size_value    (size_value),
    .blocks_in_use (blocks_in_use),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res)
  );

  // Take a new result when the output register is empty or draining
  assign res_take = !out_valid || !out_stall;

  // Output register: load on a new result, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_q <= res;
    end
  end

  assign allocated    = out_q.allocated;
  assign block_number = out_q.block_number;
  assign space_left   = out_q.space_left;

endmodule
